[src/vtpd_pkg.sv]
// shared types and constants for the vertex transform with perspective divide
`timescale 1ns / 1ps
`default_nettype none

package vtpd_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned COEF_WIDTH_DEF = 16;
  localparam int unsigned DATA_FRAC      = 16;
  localparam int unsigned COEF_FRAC      = 12;
  localparam int unsigned SLOT_BITS      = 16;
  localparam int unsigned NUM_ROWS       = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned NEAR_ZERO_W    = 31;
  localparam int unsigned ROW_W          = 64;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned MID_DEPTH      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X     = 3'd0,
    CFG_ROW_Y     = 3'd1,
    CFG_ROW_Z     = 3'd2,
    CFG_ROW_W     = 3'd3,
    CFG_DIV_EN    = 3'd4,
    CFG_NEAR_ZERO = 3'd5
  } cfg_idx_e;

  localparam logic [ROW_W-1:0]       ROW_X_RST     = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0]       ROW_Y_RST     = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0]       ROW_Z_RST     = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0]       ROW_W_RST     = 64'h1000_0000_0000_0000;
  localparam logic                   DIV_EN_RST    = 1'b1;
  localparam logic [NEAR_ZERO_W-1:0] NEAR_ZERO_RST = 31'd66;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
    logic signed [FIELD_W-1:0] w_in;
  } vtx_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      divided;
    logic                      saturated;
  } vtx_out_t;

endpackage

`default_nettype wire

[src/vtpd_fifo.sv]
// small show-ahead queue between the transform front end and the divide back end
`timescale 1ns / 1ps
`default_nettype none

module vtpd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[src/vtpd_front.sv]
// front end: config registers, input capture, matrix product, rounding and divide decision
`timescale 1ns / 1ps
`default_nettype none

module vtpd_front #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned COEF_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire vtpd_pkg::vtx_in_t                     in_i,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [vtpd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [vtpd_pkg::ROW_W-1:0]            cfg_data_i,
  output logic                                       mid_push_o,
  input  wire logic                                  mid_full_i,
  output logic [4*(DATA_WIDTH+COEF_WIDTH+2-vtpd_pkg::COEF_FRAC):0] mid_data_o
);

  import vtpd_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned CW   = COEF_WIDTH;
  localparam int unsigned PW   = DW + CW;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned TW   = SW - COEF_FRAC;
  localparam int unsigned IW   = (DW < FIELD_W) ? DW : FIELD_W;
  localparam int unsigned MAGW = (TW > NEAR_ZERO_W) ? TW : NEAR_ZERO_W;
  localparam logic signed [SW-1:0] RND_HALF = SW'(2 ** (COEF_FRAC - 1));

  logic [ROW_W-1:0]       row_q [NUM_ROWS];
  logic                   den_q;
  logic [NEAR_ZERO_W-1:0] lim_q;

  logic                   fen;
  logic                   v0_q, v1_q, v2_q, v3_q, v4_q;
  logic signed [IW-1:0]   raw [NUM_ROWS];
  logic signed [DW-1:0]   d_q [NUM_ROWS];
  logic signed [CW-1:0]   coef [NUM_ROWS][NUM_ROWS];
  logic signed [PW-1:0]   prod_q [NUM_ROWS][NUM_ROWS];
  logic signed [SW-1:0]   sum_d [NUM_ROWS];
  logic signed [SW-1:0]   sum_q [NUM_ROWS];
  logic signed [TW-1:0]   t_q [NUM_ROWS];
  logic signed [TW-1:0]   t4_q [NUM_ROWS];
  logic [TW-1:0]          wmag;
  logic                   div_d, div4_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_X_RST;
      row_q[1] <= ROW_Y_RST;
      row_q[2] <= ROW_Z_RST;
      row_q[3] <= ROW_W_RST;
      den_q    <= DIV_EN_RST;
      lim_q    <= NEAR_ZERO_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_X:     row_q[0] <= cfg_data_i;
        CFG_ROW_Y:     row_q[1] <= cfg_data_i;
        CFG_ROW_Z:     row_q[2] <= cfg_data_i;
        CFG_ROW_W:     row_q[3] <= cfg_data_i;
        CFG_DIV_EN:    den_q    <= cfg_data_i[0];
        CFG_NEAR_ZERO: lim_q    <= cfg_data_i[NEAR_ZERO_W-1:0];
        default: ;
      endcase
    end
  end

  // whole front pipe holds while the last stage waits on the queue
  assign fen        = !(v4_q && mid_full_i);
  assign full       = !fen;
  assign mid_push_o = v4_q && !mid_full_i;

  assign raw[0] = in_i.vec_x[IW-1:0];
  assign raw[1] = in_i.vec_y[IW-1:0];
  assign raw[2] = in_i.vec_z[IW-1:0];
  assign raw[3] = in_i.w_in[IW-1:0];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        coef[r][c] = row_q[r][c*SLOT_BITS +: CW];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_ROWS; c++) begin
      sum_d[c] = SW'(prod_q[0][c]) + SW'(prod_q[1][c]) + SW'(prod_q[2][c]) + SW'(prod_q[3][c]);
    end
  end

  assign wmag  = t_q[3][TW-1] ? TW'(-t_q[3]) : TW'(t_q[3]);
  assign div_d = den_q && (MAGW'(wmag) > MAGW'(lim_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (fen) begin
      v0_q <= push;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        d_q[r] <= DW'(raw[r]);
        for (int c = 0; c < NUM_ROWS; c++) begin
          prod_q[r][c] <= d_q[r] * coef[r][c];
        end
      end
      for (int c = 0; c < NUM_ROWS; c++) begin
        sum_q[c] <= sum_d[c];
        // round Q.28 to Q22.16: add half, floor
        t_q[c]   <= TW'((sum_q[c] + RND_HALF) >>> COEF_FRAC);
        t4_q[c]  <= t_q[c];
      end
      div4_q <= div_d;
    end
  end

  assign mid_data_o = {div4_q, t4_q[3], t4_q[2], t4_q[1], t4_q[0]};

endmodule

`default_nettype wire

[src/vtpd_back.sv]
// back end: pipelined restoring divide by w', rounding, saturation and result register
`timescale 1ns / 1ps
`default_nettype none

module vtpd_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned COEF_WIDTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [4*(DATA_WIDTH+COEF_WIDTH+2-vtpd_pkg::COEF_FRAC):0] mid_data_i,
  input  wire logic                mid_empty_i,
  output logic                     mid_pop_o,
  output logic                     empty,
  input  wire logic                pop,
  output vtpd_pkg::vtx_out_t       out_o
);

  import vtpd_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned TW   = DW + COEF_WIDTH + 2 - COEF_FRAC;
  localparam int unsigned RW   = TW + 1;
  localparam int unsigned QW   = DW + 1;
  localparam int unsigned NW   = TW + DATA_FRAC + 1;
  localparam int unsigned OSH  = DW - DATA_FRAC;
  localparam int unsigned CMPW = TW + OSH;
  localparam int unsigned NC   = 3;
  localparam logic signed [TW-1:0] HI_T = {{(TW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [TW-1:0] LO_T = {{(TW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [DW+1:0] HI_F = {3'b000, {(DW-1){1'b1}}};
  localparam logic signed [DW+1:0] LO_F = {3'b111, {(DW-1){1'b0}}};

  logic                 ben;
  logic signed [TW-1:0] tin [NUM_ROWS];
  logic                 div_in;

  // abs stage
  logic                 a_v_q, a_div_q;
  logic [TW-1:0]        a_ua_q [NC];
  logic [TW-1:0]        a_uw_q;
  logic                 a_neg_q [NC];
  logic [DW-1:0]        a_uval_q [NC];
  logic                 a_usat_q [NC];

  // divide stages, stage 0 is the setup
  logic                 sv_q [QW+1];
  logic                 sdiv_q [QW+1];
  logic [TW-1:0]        suw_q [QW+1];
  logic [RW-1:0]        rem_q [QW+1][NC];
  logic [RW-1:0]        rem_d [QW+1][NC];
  logic [QW-1:0]        lo_q [QW+1][NC];
  logic [QW-1:0]        lo_d [QW+1][NC];
  logic [QW-1:0]        quo_q [QW+1][NC];
  logic [QW-1:0]        quo_d [QW+1][NC];
  logic                 ovf_q [QW+1][NC];
  logic                 ovf_d [NC];
  logic                 neg_q [QW+1][NC];
  logic [DW-1:0]        uval_q [QW+1][NC];
  logic                 usat_q [QW+1][NC];
  logic [RW-1:0]        rsh;
  logic [NW-1:0]        nw;

  logic                 out_v_q;
  vtx_out_t             out_q;
  logic [DW:0]          mag [NC];
  logic signed [DW+1:0] sval [NC];
  logic [DW-1:0]        fval [NC];
  logic                 fsat [NC];
  logic                 fsat_any;

  // pipe moves whenever the result register is free or being drained
  assign ben       = !out_v_q || pop;
  assign mid_pop_o = ben && !mid_empty_i;
  assign empty     = !out_v_q;
  assign out_o     = out_q;

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      tin[i] = mid_data_i[i*TW +: TW];
    end
  end
  assign div_in = mid_data_i[4*TW];

  always_ff @(posedge clk_i) begin
    if (ben) begin
      a_div_q <= div_in;
      a_uw_q  <= tin[3][TW-1] ? TW'(-tin[3]) : TW'(tin[3]);
      for (int i = 0; i < NC; i++) begin
        a_ua_q[i]   <= tin[i][TW-1] ? TW'(-tin[i]) : TW'(tin[i]);
        a_neg_q[i]  <= tin[i][TW-1] ^ tin[3][TW-1];
        a_uval_q[i] <= (tin[i] > HI_T) ? HI_T[DW-1:0] :
                       (tin[i] < LO_T) ? LO_T[DW-1:0] : tin[i][DW-1:0];
        a_usat_q[i] <= (tin[i] > HI_T) || (tin[i] < LO_T);
      end
    end
  end

  always_comb begin
    nw  = '0;
    rsh = '0;
    for (int i = 0; i < NC; i++) begin
      // quotient would need more than DATA_WIDTH+1 bits
      ovf_d[i]    = CMPW'(a_ua_q[i]) >= (CMPW'(a_uw_q) << OSH);
      nw          = {a_ua_q[i], {(DATA_FRAC+1){1'b0}}};
      rem_d[0][i] = RW'(nw >> QW);
      lo_d[0][i]  = nw[QW-1:0];
      quo_d[0][i] = '0;
    end
    for (int s = 1; s <= QW; s++) begin
      for (int i = 0; i < NC; i++) begin
        rsh = {rem_q[s-1][i][RW-2:0], lo_q[s-1][i][QW-1]};
        if (rsh >= RW'(suw_q[s-1])) begin
          rem_d[s][i] = rsh - RW'(suw_q[s-1]);
          quo_d[s][i] = {quo_q[s-1][i][QW-2:0], 1'b1};
        end else begin
          rem_d[s][i] = rsh;
          quo_d[s][i] = {quo_q[s-1][i][QW-2:0], 1'b0};
        end
        lo_d[s][i] = {lo_q[s-1][i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      sdiv_q[0] <= a_div_q;
      suw_q[0]  <= a_uw_q;
      for (int i = 0; i < NC; i++) begin
        ovf_q[0][i]  <= ovf_d[i];
        neg_q[0][i]  <= a_neg_q[i];
        uval_q[0][i] <= a_uval_q[i];
        usat_q[0][i] <= a_usat_q[i];
      end
      for (int s = 1; s <= QW; s++) begin
        sdiv_q[s] <= sdiv_q[s-1];
        suw_q[s]  <= suw_q[s-1];
        for (int i = 0; i < NC; i++) begin
          ovf_q[s][i]  <= ovf_q[s-1][i];
          neg_q[s][i]  <= neg_q[s-1][i];
          uval_q[s][i] <= uval_q[s-1][i];
          usat_q[s][i] <= usat_q[s-1][i];
        end
      end
      for (int s = 0; s <= QW; s++) begin
        for (int i = 0; i < NC; i++) begin
          rem_q[s][i] <= rem_d[s][i];
          lo_q[s][i]  <= lo_d[s][i];
          quo_q[s][i] <= quo_d[s][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      // quotient carries one extra fraction bit: round half away from zero
      mag[i]  = ovf_q[QW][i] ? ((DW+1)'(1) << DW)
                             : (DW+1)'(quo_q[QW][i][QW-1:1]) + (DW+1)'(quo_q[QW][i][0]);
      sval[i] = neg_q[QW][i] ? -signed'((DW+2)'(mag[i])) : signed'((DW+2)'(mag[i]));
      if (!sdiv_q[QW]) begin
        fval[i] = uval_q[QW][i];
        fsat[i] = usat_q[QW][i];
      end else if (sval[i] > HI_F) begin
        fval[i] = HI_F[DW-1:0];
        fsat[i] = 1'b1;
      end else if (sval[i] < LO_F) begin
        fval[i] = LO_F[DW-1:0];
        fsat[i] = 1'b1;
      end else begin
        fval[i] = sval[i][DW-1:0];
        fsat[i] = 1'b0;
      end
    end
    fsat_any = fsat[0] || fsat[1] || fsat[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        sv_q[s] <= 1'b0;
      end
    end else if (ben) begin
      a_v_q   <= mid_pop_o;
      sv_q[0] <= a_v_q;
      for (int s = 1; s <= QW; s++) begin
        sv_q[s] <= sv_q[s-1];
      end
      out_v_q <= sv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      out_q.out_x     <= FIELD_W'(fval[0]);
      out_q.out_y     <= FIELD_W'(fval[1]);
      out_q.out_z     <= FIELD_W'(fval[2]);
      out_q.divided   <= sdiv_q[QW];
      out_q.saturated <= fsat_any;
    end
  end

endmodule

`default_nettype wire

[src/vertex_transform_persp_divide_top.sv]
// Vertex transform with perspective divide.
// Input side is a queue: drive in_i and raise push; the vertex is taken on
// an edge where push is high and full is low. Result side is a queue too:
// while empty is low out_o holds the oldest result, and it is taken on an
// edge where pop is high. One result comes out for every vertex.
// Matrix rows, divide enable and near-zero limit are written over the cfg
// channel (cfg_ready_o is always high); write them only while idle.
// From acceptance to empty going low a vertex passes five front stages for
// capture, multiply, column sum, rounding and divide decision, a queue slot,
// then an abs stage, a setup stage, one restoring divider stage per quotient
// bit and the result register. Throughput is one vertex per cycle while pop
// keeps up; the divider is fully pipelined.
// When pop is held low the back pipe freezes; the four-entry queue between
// front and back absorbs the front's output until it fills, then full rises.
// Reset loads the identity matrix, divide enable 1 and limit 66 and empties
// all stages.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_persp_divide_top #(
  parameter int unsigned DATA_WIDTH = vtpd_pkg::DATA_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH = vtpd_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire vtpd_pkg::vtx_in_t              in_i,
  output logic                                empty,
  input  wire logic                           pop,
  output vtpd_pkg::vtx_out_t                  out_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vtpd_pkg::ROW_W-1:0]     cfg_data_i
);

  import vtpd_pkg::*;

  localparam int unsigned TW = DATA_WIDTH + COEF_WIDTH + 2 - COEF_FRAC;
  localparam int unsigned MW = 4 * TW + 1;

  logic          mq_push, mq_full, mq_pop, mq_empty;
  logic [MW-1:0] mq_wdata, mq_rdata;

  vtpd_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mid_push_o  (mq_push),
    .mid_full_i  (mq_full),
    .mid_data_o  (mq_wdata)
  );

  vtpd_fifo #(
    .WIDTH (MW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (mq_push),
    .wdata_i (mq_wdata),
    .full_o  (mq_full),
    .rd_en_i (mq_pop),
    .rdata_o (mq_rdata),
    .empty_o (mq_empty)
  );

  vtpd_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_data_i  (mq_rdata),
    .mid_empty_i (mq_empty),
    .mid_pop_o   (mq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

  // front never pushes into a full queue, back never pops an empty one
  a_mq_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_full |-> !mq_push)
    else $error("mid queue push while full");

  a_mq_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_empty |-> !mq_pop)
    else $error("mid queue pop while empty");

  // front stalls only because the queue is full
  a_full_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> mq_full)
    else $error("input stalled with room in mid queue");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for the vertex transform with perspective divide
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import vtpd_pkg::*;

  localparam int unsigned DW = DATA_WIDTH_DEF;
  localparam int unsigned CW = COEF_WIDTH_DEF;
  localparam int unsigned SETTLE = DW + 40;
  localparam int unsigned STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  vtx_in_t in_i = '0;
  logic empty;
  logic pop = 1'b0;
  vtx_out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ROW_W-1:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  vertex_transform_persp_divide_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // predictor copy of the registers
  logic [ROW_W-1:0] mat_row [NUM_ROWS];
  logic div_en;
  logic [NEAR_ZERO_W-1:0] near_lim;

  vtx_in_t pending_vtx[$];
  vtx_out_t expected_vtx[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int divided_seen = 0;
  int sat_seen = 0;
  bit hold_push = 1'b0;
  bit rand_pop = 1'b1;
  // set at the edge that takes a transaction, consumed at the next falling edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  function automatic logic signed [63:0] coef_at(int r, int c);
    logic [15:0] slot;
    slot = mat_row[r][SLOT_BITS*c +: SLOT_BITS];
    return 64'(signed'(slot[CW-1:0]));
  endfunction

  function automatic logic signed [127:0] clamp_dw(logic signed [127:0] v, ref bit sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // round-half-away quotient of t * 2^16 / w, w nonzero
  function automatic logic signed [127:0] persp_quot(logic signed [127:0] t,
      logic signed [127:0] w, ref bit sat);
    logic neg;
    logic [127:0] ut, uw, q2, mag;
    neg = (t < 0) != (w < 0);
    ut = (t < 0) ? -t : t;
    uw = (w < 0) ? -w : w;
    q2 = (ut << (DATA_FRAC + 1)) / uw;
    mag = (q2 >> 1) + q2[0];
    if ((ut / uw) >= (128'd1 << (DW - DATA_FRAC))) mag = 128'd1 << DW;
    return clamp_dw(neg ? -$signed(mag) : $signed(mag), sat);
  endfunction

  function automatic vtx_out_t transform_vertex(vtx_in_t v);
    logic signed [127:0] d [4];
    logic signed [127:0] col [4];
    logic signed [127:0] r [3];
    logic [127:0] wmag;
    bit sat, dv;
    vtx_out_t o;
    sat = 1'b0;
    d[0] = v.vec_x; d[1] = v.vec_y; d[2] = v.vec_z; d[3] = v.w_in;
    for (int c = 0; c < 4; c++) begin
      col[c] = 0;
      for (int k = 0; k < 4; k++) col[c] += d[k] * coef_at(k, c);
      // exact sum, plus half, floor
      col[c] = (col[c] + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    end
    wmag = (col[3] < 0) ? -col[3] : col[3];
    dv = div_en && (wmag > near_lim);
    for (int i = 0; i < 3; i++)
      r[i] = dv ? persp_quot(col[i], col[3], sat) : clamp_dw(col[i], sat);
    o.out_x = r[0][31:0];
    o.out_y = r[1][31:0];
    o.out_z = r[2][31:0];
    o.divided = dv;
    o.saturated = sat;
    return o;
  endfunction

  // driver
  int push_gap = 0;
  always @(negedge clk_i) begin
    bit took;
    took = in_taken;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (took) push_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      if (push && !took) begin
        // hold item
      end else if (pending_vtx.size() > 0 && !hold_push && push_gap == 0) begin
        in_i <= pending_vtx[0];
        push <= 1'b1;
      end else begin
        push <= 1'b0;
        if (push_gap > 0) push_gap--;
      end
    end
  end

  // monitor and receiver stall
  int pop_gap = 0;
  always @(posedge clk_i) begin
    vtx_out_t e;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      out_taken = 1'b1;
      if (expected_vtx.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = expected_vtx.pop_front();
        if (out_o.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, out_o.out_x); errors++;
        end
        if (out_o.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, out_o.out_y); errors++;
        end
        if (out_o.out_z !== e.out_z) begin
          $error("out_z exp %h got %h", e.out_z, out_o.out_z); errors++;
        end
        if (out_o.divided !== e.divided) begin
          $error("divided exp %b got %b", e.divided, out_o.divided); errors++;
        end
        if (out_o.saturated !== e.saturated) begin
          $error("saturated exp %b got %b", e.saturated, out_o.saturated); errors++;
        end
        divided_seen += out_o.divided;
        sat_seen += out_o.saturated;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      pop_gap = rand_pop ? $urandom_range(0, 6) : 0;
    end
    if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else begin
      pop <= 1'b1;
    end
  end

  // expectations are computed at acceptance, with the config of that moment
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      expected_vtx.push_back(transform_vertex(in_i));
      void'(pending_vtx.pop_front());
      accepted++;
      in_taken = 1'b1;
    end
  end

  // watchdog on cycles with no transaction
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_valid_i) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [ROW_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROW_X: mat_row[0] = val;
      CFG_ROW_Y: mat_row[1] = val;
      CFG_ROW_Z: mat_row[2] = val;
      CFG_ROW_W: mat_row[3] = val;
      CFG_DIV_EN: div_en = val[0];
      CFG_NEAR_ZERO: near_lim = val[NEAR_ZERO_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_vtx.size() > 0 || push || expected_vtx.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      3: return 32'(signed'($urandom_range(0, 400)) - 200);
      default: return $urandom();
    endcase
  endfunction

  function automatic vtx_in_t rand_vtx();
    vtx_in_t v;
    v.vec_x = rand_field();
    v.vec_y = rand_field();
    v.vec_z = rand_field();
    // points mostly with w between 0 and 2.0
    v.w_in = $urandom_range(0, 2) ? 32'(signed'($urandom_range(0, 1 << 17))) : rand_field();
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] r;
    for (int c = 0; c < 4; c++)
      case ($urandom_range(0, 3))
        0: r[16*c +: 16] = 16'(signed'($urandom_range(0, 8192)) - 4096);
        1: r[16*c +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: r[16*c +: 16] = 16'($urandom());
      endcase
    return r;
  endfunction

  task automatic queue_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
      logic [31:0] w);
    vtx_in_t v;
    v.vec_x = x; v.vec_y = y; v.vec_z = z; v.w_in = w;
    pending_vtx.push_back(v);
  endtask

  initial begin
    mat_row[0] = ROW_X_RST; mat_row[1] = ROW_Y_RST;
    mat_row[2] = ROW_Z_RST; mat_row[3] = ROW_W_RST;
    div_en = DIV_EN_RST;
    near_lim = NEAR_ZERO_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings: extremes, w' of zero, near limit, ties
    queue_vtx(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    queue_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    queue_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0000_0001);
    queue_vtx(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    queue_vtx(32'h0001_0000, 32'hffff_0000, 32'h5, 32'd66);
    queue_vtx(32'h0001_0000, 32'hffff_0000, 32'h5, 32'd67);
    queue_vtx(32'h0001_0000, 32'h0, 32'h3, 32'hffff_ffbd);
    queue_vtx(32'h0000_0001, 32'h0000_0003, 32'h0, 32'h0002_0000);
    queue_vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vtx(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_vtx(32'hffff_ffff, 32'h1, 32'h0, 32'hffff_0000);
    drain_all();

    // extreme coefficients, divide off
    write_reg(CFG_ROW_X, 64'h7fff_8000_7fff_8000);
    write_reg(CFG_ROW_Y, 64'h8000_7fff_8000_7fff);
    write_reg(CFG_ROW_Z, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_ROW_W, 64'h0);
    write_reg(CFG_DIV_EN, 64'h0);
    write_reg(CFG_NEAR_ZERO, 64'h7fff_ffff);
    for (int i = 0; i < 8; i++) pending_vtx.push_back(rand_vtx());
    queue_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    drain_all();

    // random phases over random settings, one with no receiver stall
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_ROW_X, (ph % 3 == 0) ? ROW_X_RST : rand_row());
      write_reg(CFG_ROW_Y, (ph % 3 == 0) ? ROW_Y_RST : rand_row());
      write_reg(CFG_ROW_Z, (ph % 3 == 0) ? ROW_Z_RST : rand_row());
      write_reg(CFG_ROW_W, (ph % 2 == 0) ? ROW_W_RST : rand_row());
      write_reg(CFG_DIV_EN, (ph % 4 == 3) ? 64'h0 : 64'h1);
      case (ph % 3)
        0: write_reg(CFG_NEAR_ZERO, 64'h0);
        1: write_reg(CFG_NEAR_ZERO, 64'(NEAR_ZERO_RST));
        default: write_reg(CFG_NEAR_ZERO, 64'($urandom_range(0, 1 << 18)));
      endcase
      rand_pop = (ph != 5);
      for (int i = 0; i < 135; i++) pending_vtx.push_back(rand_vtx());
      if (ph == 7) begin
        // sender holds off until every result is back
        while (pending_vtx.size() > 60) @(posedge clk_i);
        hold_push = 1'b1;
        while (push || expected_vtx.size() > 0) @(posedge clk_i);
        hold_push = 1'b0;
      end
      drain_all();
    end

    $display("run: %0d vertices sent, %0d results checked", accepted, results_seen);
    $display("run: %0d divided, %0d saturated, 14 register settings", divided_seen,
             sat_seen);
    if (errors == 0 && expected_vtx.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
src/vtpd_pkg.sv
src/vtpd_fifo.sv
src/vtpd_front.sv
src/vtpd_back.sv
src/vertex_transform_persp_divide_top.sv
verif/tb_top.sv
